// ----- rtl/core/dvg_pkg.sv -----
// Package for the dependency violation grouper: constants, result kinds, FSM states.
// No dependencies.
`default_nettype none
package dvg_pkg;
  localparam int unsigned DefGroups = 256;
  localparam int unsigned DefMaxIds = 16;
  localparam int unsigned KeyW = 64;
  localparam int unsigned RhsW = 64;
  localparam int unsigned IdW  = 32;
  localparam int unsigned CntW = 5;

  typedef enum logic [1:0] {
    KIND_VIOLATION = 2'd0,
    KIND_TABLE_FULL = 2'd1,
    KIND_LIST_FULL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_DUMP,
    ST_LAST
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] lhs_key;
    logic [RhsW-1:0] rhs_value;
    logic [IdW-1:0]  tuple_id;
  } item_t;

  typedef struct packed {
    logic [IdW-1:0] violating_id;
    kind_e          kind;
    logic           last;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/core/dvg_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload type given by parameter.
`default_nettype none
interface dvg_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dvg_table.sv -----
// Group table memory: key, right side, consistent mark and id count per entry.
// Depends on dvg_pkg. Valid bits in flip-flops, payload in a memory with a registered read.
`default_nettype none
module dvg_table #(
  parameter int unsigned Groups = dvg_pkg::DefGroups,
  parameter int unsigned GW = $clog2(Groups)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [GW-1:0]          rd_addr_i,
  output logic [dvg_pkg::KeyW-1:0]    rd_key_o,
  output logic [dvg_pkg::RhsW-1:0]    rd_rhs_o,
  output logic                        rd_cons_o,
  output logic [dvg_pkg::CntW-1:0]    rd_cnt_o,
  output logic                        rd_valid_o,
  input  wire logic                   wr_en_i,
  input  wire logic                   wr_new_i,
  input  wire logic [GW-1:0]          wr_addr_i,
  input  wire logic [dvg_pkg::KeyW-1:0] wr_key_i,
  input  wire logic [dvg_pkg::RhsW-1:0] wr_rhs_i,
  input  wire logic                   wr_cons_i,
  input  wire logic [dvg_pkg::CntW-1:0] wr_cnt_i
);
  import dvg_pkg::*;
  localparam int unsigned EW = KeyW + RhsW + 1 + CntW;

  logic [EW-1:0]     mem [Groups];
  logic [EW-1:0]     rd_q;
  logic [Groups-1:0] valid_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_key_i, wr_rhs_i, wr_cons_i, wr_cnt_i};
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i && wr_new_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign {rd_key_o, rd_rhs_o, rd_cons_o, rd_cnt_o} = rd_q;
  assign rd_valid_o = rd_valid_q;
endmodule
`default_nettype wire

// ----- rtl/core/dvg_ids.sv -----
// Id store memory: MAX_IDS ids per group, one write and one registered read a cycle.
// Depends on dvg_pkg.
`default_nettype none
module dvg_ids #(
  parameter int unsigned Depth = dvg_pkg::DefGroups * dvg_pkg::DefMaxIds,
  parameter int unsigned AW = $clog2(Depth)
) (
  input  wire logic                  clk_i,
  input  wire logic                  wr_en_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [dvg_pkg::IdW-1:0] wr_data_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output logic [dvg_pkg::IdW-1:0]    rd_data_o
);
  import dvg_pkg::*;
  logic [IdW-1:0] mem [Depth];
  logic [IdW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;
endmodule
`default_nettype wire

// ----- rtl/core/dependency_violation_grouper_core.sv -----
// Dependency violation grouper: incremental check of one functional dependency.
// Flow: a table walk (one read a cycle, ending early on a key hit), then a decide state; a result
// beat follows only on a violation or a full table or list, and a breaking group first dumps its ids.
// One item at a time: a new item is taken only in idle; output stalls hold the block in its state.
// Reset: asynchronous active low; clears all valid bits at once, rhs_enabled returns to 1.
// Depends on dvg_pkg, dvg_if, dvg_table, dvg_ids.
`default_nettype none
module dependency_violation_grouper_core #(
  parameter int unsigned Groups = dvg_pkg::DefGroups,
  parameter int unsigned MaxIds = dvg_pkg::DefMaxIds
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dvg_if.sink       in_if,
  dvg_if.source     out_if,
  dvg_if.sink       cfg_if
);
  import dvg_pkg::*;

  localparam int unsigned GW   = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned IW   = (MaxIds > 1) ? $clog2(MaxIds) : 1;
  localparam int unsigned AW   = GW + IW;
  localparam int unsigned GCW  = GW + 1;

  // Configuration: one register, always ready.
  logic rhs_en_q;
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhs_en_q <= 1'b1;
    end else if (cfg_if.valid) begin
      rhs_en_q <= cfg_if.payload[0];
    end
  end

  state_e state_q, state_d;
  item_t  item_q;
  logic [GCW-1:0] rd_idx_q, rd_idx_d;   // address issued this cycle
  logic [GCW-1:0] cmp_idx_q, cmp_idx_d; // address whose data is on the read port
  logic           cmp_vld_q, cmp_vld_d;
  logic           hit_q, hit_d;
  logic [GW-1:0]  hit_idx_q, hit_idx_d;
  logic           free_q, free_d;
  logic [GW-1:0]  free_idx_q, free_idx_d;
  logic [CntW-1:0] dump_n_q, dump_n_d;
  logic [CntW-1:0] dump_i_q, dump_i_d;
  logic           dump_vld_q, dump_vld_d;
  result_t        res_q, res_d;
  logic           res_vld_q, res_vld_d;

  // Table port
  logic [GW-1:0]   t_rd_addr;
  logic [KeyW-1:0] t_key;
  logic [RhsW-1:0] t_rhs;
  logic            t_cons, t_valid;
  logic [CntW-1:0] t_cnt;
  logic            t_wr_en, t_wr_new;
  logic [GW-1:0]   t_wr_addr;
  logic            t_wr_cons;
  logic [CntW-1:0] t_wr_cnt;
  logic [RhsW-1:0] t_wr_rhs;
  // Id port
  logic            i_wr_en;
  logic [AW-1:0]   i_wr_addr, i_rd_addr;
  logic [IdW-1:0]  i_rd_data;

  dvg_table #(.Groups(Groups), .GW(GW)) u_table (
    .clk_i, .rst_ni,
    .rd_addr_i(t_rd_addr), .rd_key_o(t_key), .rd_rhs_o(t_rhs),
    .rd_cons_o(t_cons), .rd_cnt_o(t_cnt), .rd_valid_o(t_valid),
    .wr_en_i(t_wr_en), .wr_new_i(t_wr_new), .wr_addr_i(t_wr_addr),
    .wr_key_i(item_q.lhs_key), .wr_rhs_i(t_wr_rhs),
    .wr_cons_i(t_wr_cons), .wr_cnt_i(t_wr_cnt)
  );

  dvg_ids #(.Depth(Groups << IW), .AW(AW)) u_ids (
    .clk_i,
    .wr_en_i(i_wr_en), .wr_addr_i(i_wr_addr), .wr_data_i(item_q.tuple_id),
    .rd_addr_i(i_rd_addr), .rd_data_o(i_rd_data)
  );

  // The output register may hold a beat while the next is prepared only when free.
  logic out_free;
  assign out_free     = !res_vld_q || out_if.ready;
  assign out_if.valid = res_vld_q;
  assign out_if.payload = res_q;
  assign in_if.ready  = (state_q == ST_IDLE);

  logic [CntW-1:0] max_ids_c;
  assign max_ids_c = CntW'(MaxIds);

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = 1'b0;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    dump_n_d   = dump_n_q;
    dump_i_d   = dump_i_q;
    dump_vld_d = 1'b0;
    res_d      = res_q;
    res_vld_d  = res_vld_q && !out_if.ready;
    t_rd_addr  = rd_idx_q[GW-1:0];
    t_wr_en    = 1'b0;
    t_wr_new   = 1'b0;
    t_wr_addr  = hit_idx_q;
    t_wr_cons  = 1'b1;
    t_wr_cnt   = t_cnt;
    t_wr_rhs   = t_rhs;
    i_wr_en    = 1'b0;
    i_wr_addr  = {hit_idx_q, t_cnt[IW-1:0]};
    i_rd_addr  = {hit_idx_q, dump_i_q[IW-1:0]};

    case (state_q)
      ST_IDLE: begin
        if (in_if.valid && rhs_en_q) begin
          state_d  = ST_SEARCH;
          rd_idx_d = '0;
          hit_d    = 1'b0;
          free_d   = 1'b0;
        end
      end
      ST_SEARCH: begin
        // Issue one read a cycle; compare the entry read last cycle.
        if (cmp_vld_q) begin
          if (t_valid) begin
            if (t_key == item_q.lhs_key) begin
              hit_d     = 1'b1;
              hit_idx_d = cmp_idx_q[GW-1:0];
            end
          end else if (!free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx_q[GW-1:0];
          end
        end
        if (hit_d) begin
          // Re-read the hit entry so its fields sit on the port.
          t_rd_addr = hit_idx_d;
          state_d   = ST_DECIDE;
        end else if (rd_idx_q == GCW'(Groups)) begin
          if (!cmp_vld_q || cmp_idx_q == GCW'(Groups - 1)) begin
            state_d = ST_DECIDE;
          end
        end else begin
          cmp_idx_d = rd_idx_q;
          cmp_vld_d = 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        // Keep the hit entry on the read port while the output is busy.
        t_rd_addr = hit_idx_q;
        if (!hit_q) begin
          if (!free_q) begin
            if (out_free) begin
              res_d     = '{violating_id: item_q.tuple_id, kind: KIND_TABLE_FULL, last: 1'b1};
              res_vld_d = 1'b1;
              state_d   = ST_IDLE;
            end
          end else begin
            t_wr_en   = 1'b1;
            t_wr_new  = 1'b1;
            t_wr_addr = free_idx_q;
            t_wr_rhs  = item_q.rhs_value;
            t_wr_cnt  = CntW'(1);
            i_wr_en   = 1'b1;
            i_wr_addr = {free_idx_q, IW'(0)};
            state_d   = ST_IDLE;
          end
        end else if (!t_cons) begin
          if (out_free) begin
            res_d     = '{violating_id: item_q.tuple_id, kind: KIND_VIOLATION, last: 1'b1};
            res_vld_d = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (t_rhs == item_q.rhs_value) begin
          if (t_cnt >= max_ids_c) begin
            if (out_free) begin
              res_d     = '{violating_id: item_q.tuple_id, kind: KIND_LIST_FULL, last: 1'b1};
              res_vld_d = 1'b1;
              state_d   = ST_IDLE;
            end
          end else begin
            t_wr_en  = 1'b1;
            t_wr_cnt = t_cnt + 1'b1;
            i_wr_en  = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          // Mark inconsistent, then stream the stored ids.
          t_wr_en   = 1'b1;
          t_wr_cons = 1'b0;
          dump_n_d  = (t_cnt > max_ids_c) ? max_ids_c : t_cnt;
          dump_i_d  = '0;
          state_d   = ST_DUMP;
        end
      end
      ST_DUMP: begin
        // Read id dump_i; the previous read's data is emitted once the output frees.
        if (dump_vld_q) begin
          if (out_free) begin
            res_d     = '{violating_id: i_rd_data, kind: KIND_VIOLATION, last: 1'b0};
            res_vld_d = 1'b1;
          end else begin
            dump_vld_d = 1'b1;
            i_rd_addr  = {hit_idx_q, IW'(dump_i_q - 1'b1)};
          end
        end
        if (!dump_vld_q || out_free) begin
          if (dump_i_q == dump_n_q) begin
            state_d = ST_LAST;
          end else begin
            dump_vld_d = 1'b1;
            dump_i_d   = dump_i_q + 1'b1;
          end
        end
      end
      ST_LAST: begin
        if (out_free) begin
          res_d     = '{violating_id: item_q.tuple_id, kind: KIND_VIOLATION, last: 1'b1};
          res_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmp_vld_q  <= 1'b0;
      dump_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmp_vld_q  <= cmp_vld_d;
      dump_vld_q <= dump_vld_d;
      res_vld_q  <= res_vld_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
    end
  end

  // Payload and index registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      item_q <= in_if.payload;
    end
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    dump_n_q   <= dump_n_d;
    dump_i_q   <= dump_i_d;
    res_q      <= res_d;
  end
endmodule
`default_nettype wire
